// ===== hdl/tdl_pkg.sv =====
`default_nettype none
package tdl_pkg;

   localparam int NUM_STATES = 16;
   localparam int MAX_TOKEN  = 32;
   localparam int MAX_REFEED = 4;

   localparam int STATE_W = $clog2(NUM_STATES);
   localparam int ADDR_W  = STATE_W + 8;
   localparam int CNT_W   = $clog2(MAX_TOKEN + 1);
   localparam int IDX_W   = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
   localparam int PASS_W  = $clog2(MAX_REFEED + 1);
   localparam int ENTRY_W = 1 + 3 + 4 + 8;

   typedef enum logic [1:0] {
      OP_ADD_ROW = 2'd0,
      OP_RANGE   = 2'd1,
      OP_FEED    = 2'd2,
      OP_RESTART = 2'd3
   } op_code_type;

   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_MOVE        = 3'd1;
   localparam logic [2:0] ACT_MOVE_REFEED = 3'd2;
   localparam logic [2:0] ACT_EMIT        = 3'd3;
   localparam logic [2:0] ACT_ERROR       = 3'd4;

   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] state_id;
      logic [7:0] char_low;
      logic [7:0] char_high;
      logic [3:0] next_state;
      logic [2:0] action;
      logic [7:0] token_kind;
      logic [7:0] in_char;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  token_char;
      logic [7:0]  token_type;
      logic        last;
      logic        truncated;
      logic [31:0] position;
   } rsp_type;

   typedef struct packed {
      op_code_type op;
      logic        range_ok;
      req_type     req;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } ctl_type;

endpackage
`default_nettype wire

// ===== hdl/table_driven_lexer_fsm_top.sv =====
`default_nettype none
// Programmable table-driven lexer.
// Commands enter on start/req_data and are taken when busy is low. A front
// queue of two entries holds them while the back end walks the transition
// table. Results leave on rsp_valid/rsp_data, one per cycle, and are never
// held off. The last result of a command carries rsp_data.last.
// A table row add sweeps all 256 entries of its row; a range write sweeps
// each byte of the range, and none if char_low is above char_high. A fed
// byte makes up to four table passes, each through lookup and evaluation,
// and gives one result per streamed token character. A result is held in
// a pending register until the next is found or the command is done, so
// that the last one can carry its flag. Restart gives no result.
// After reset the table memory is cleared, one entry a cycle, over all
// 4096 entries; busy stays high during that pass. The start state register
// is written on the csr channel, which is always ready; the user must write
// it only while the block is idle, as the block does not enforce this.
module table_driven_lexer_fsm_top (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  tdl_pkg::req_type     req_data,
   output logic                 rsp_valid,
   output tdl_pkg::rsp_type     rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [3:0]            csr_data
);
   import tdl_pkg::*;

   logic [3:0] start_state_ff;
   logic       cmd_valid;
   cmd_type    cmd;
   ctl_type    ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         start_state_ff <= csr_data;
      end
   end

   tdl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .ctl       (ctl),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   tdl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .start_state (start_state_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .ctl         (ctl),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_INVALID |-> rsp_data.last)
      else $error("invalid-state result is not the last of its transaction");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_ERROR |-> rsp_data.last)
      else $error("lexical error result is not the last of its transaction");

   a_char_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_CHAR |-> rsp_data.token_char == 8'd0)
      else $error("token character set on a non-character result");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clearing |-> !rsp_valid && busy)
      else $error("activity during the table clearing pass");
`endif

endmodule
`default_nettype wire

// ===== hdl/tdl_front.sv =====
`default_nettype none
module tdl_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  tdl_pkg::req_type     req_data,
   input  tdl_pkg::ctl_type     ctl,
   output logic                 cmd_valid,
   output tdl_pkg::cmd_type     cmd
);
   import tdl_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;
   cmd_type    cmd_in;

   always_comb begin
      cmd_in.op       = op_code_type'(req_data.op);
      cmd_in.range_ok = (req_data.char_low <= req_data.char_high);
      cmd_in.req      = req_data;
   end

   assign busy      = (count_ff == 2'd2) || ctl.clearing;
   assign push      = start && !busy;
   assign pop       = ctl.pop && (count_ff != 2'd0);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tdl_back.sv =====
`default_nettype none
module tdl_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [3:0]            start_state,
   input  wire                  cmd_valid,
   input  tdl_pkg::cmd_type     cmd,
   output tdl_pkg::ctl_type     ctl,
   output logic                 rsp_valid,
   output tdl_pkg::rsp_type     rsp_data
);
   import tdl_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SWEEP, S_LOOKUP, S_EVAL, S_STREAM, S_CHECK, S_DONE
   } state_type;

   state_type            state_ff;
   logic [ENTRY_W-1:0]   table_mem_ff [NUM_STATES*256];
   logic [ENTRY_W-1:0]   rd_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [7:0]           sweep_end_ff;
   logic [ENTRY_W-1:0]   sweep_data_ff;
   logic [NUM_STATES-1:0] row_valid_ff;
   logic [STATE_W-1:0]   cur_ff;
   logic [7:0]           char_ff;
   logic [7:0]           buf_ff [MAX_TOKEN];
   logic [CNT_W-1:0]     cnt_ff;
   logic                 ovf_ff;
   logic [31:0]          bpos_ff;
   logic [31:0]          pos_ff;
   logic [PASS_W-1:0]    pass_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [7:0]           type_ff;
   logic                 pend_vld_ff;
   rsp_type              pend_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 mem_we;
   logic [ENTRY_W-1:0]   mem_wd;
   logic [2:0]           e_act;
   logic                 push_vld;
   rsp_type              push_rsp;
   logic                 pop;
   logic                 pass_end;
   logic                 rsp_valid_in;
   rsp_type              rsp_in;

   assign pop      = (state_ff == S_IDLE) && cmd_valid;
   assign ctl.pop      = pop;
   assign ctl.clearing = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pass_end  = (pass_ff >= PASS_W'(MAX_REFEED));

   // An entry not written since its row was added acts as an error.
   assign e_act = rd_ff[ENTRY_W-1] ? rd_ff[ENTRY_W-2 -: 3] : ACT_ERROR;

   assign mem_we = (state_ff == S_CLEAR) || (state_ff == S_SWEEP);
   assign mem_wd = (state_ff == S_SWEEP) ? sweep_data_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem_ff[addr_ff] <= mem_wd;
      end
      rd_ff <= table_mem_ff[{cur_ff, char_ff}];
   end

   always_comb begin
      push_vld            = 1'b0;
      push_rsp.kind       = KIND_ERROR;
      push_rsp.token_char = 8'd0;
      push_rsp.token_type = 8'd0;
      push_rsp.last       = 1'b0;
      push_rsp.truncated  = 1'b0;
      push_rsp.position   = pos_ff;
      case (state_ff)
         S_LOOKUP: begin
            if (!row_valid_ff[cur_ff]) begin
               push_vld      = 1'b1;
               push_rsp.kind = KIND_INVALID;
            end
         end
         S_EVAL: begin
            case (e_act)
               ACT_NONE, ACT_MOVE, ACT_MOVE_REFEED: begin
                  push_vld = 1'b0;
               end
               ACT_EMIT: begin
                  if (cnt_ff == '0) begin
                     push_vld            = 1'b1;
                     push_rsp.kind       = KIND_EMPTY;
                     push_rsp.token_type = rd_ff[7:0];
                     push_rsp.truncated  = ovf_ff;
                  end
               end
               default: begin
                  push_vld = 1'b1;
               end
            endcase
         end
         S_STREAM: begin
            push_vld            = 1'b1;
            push_rsp.kind       = KIND_CHAR;
            push_rsp.token_char = buf_ff[idx_ff];
            push_rsp.token_type = type_ff;
            push_rsp.truncated  = ovf_ff;
         end
         S_CHECK: begin
            push_vld = pass_end;
         end
         default: begin
            push_vld = 1'b0;
         end
      endcase
   end

   // A result is held back until the next one is found or the command ends, so that its last flag is known.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = pend_ff;
      if (pend_vld_ff) begin
         if (push_vld) begin
            rsp_valid_in = 1'b1;
         end else if (state_ff == S_DONE) begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         row_valid_ff <= '0;
         cur_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         bpos_ff      <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_valid_in) begin
            rsp_ff <= rsp_in;
         end
         if (push_vld) begin
            pend_ff     <= push_rsp;
            pend_vld_ff <= 1'b1;
         end else if (state_ff == S_DONE) begin
            pend_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop) begin
                  case (cmd.op)
                     OP_ADD_ROW: begin
                        row_valid_ff[cmd.req.state_id] <= 1'b1;
                        addr_ff       <= {cmd.req.state_id, 8'h00};
                        sweep_end_ff  <= 8'hFF;
                        sweep_data_ff <= '0;
                        state_ff      <= S_SWEEP;
                     end
                     OP_RANGE: begin
                        addr_ff       <= {cmd.req.state_id, cmd.req.char_low};
                        sweep_end_ff  <= cmd.req.char_high;
                        sweep_data_ff <= {1'b1, cmd.req.action, cmd.req.next_state,
                                          cmd.req.token_kind};
                        if (cmd.range_ok) begin
                           state_ff <= S_SWEEP;
                        end
                     end
                     OP_RESTART: begin
                        cur_ff  <= start_state;
                        cnt_ff  <= '0;
                        ovf_ff  <= 1'b0;
                        bpos_ff <= '0;
                     end
                     default: begin
                        char_ff  <= cmd.req.in_char;
                        pos_ff   <= bpos_ff;
                        bpos_ff  <= bpos_ff + 32'd1;
                        pass_ff  <= PASS_W'(1);
                        state_ff <= S_LOOKUP;
                     end
                  endcase
               end
            end
            S_SWEEP: begin
               addr_ff[7:0] <= addr_ff[7:0] + 8'd1;
               if (addr_ff[7:0] == sweep_end_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_LOOKUP: begin
               state_ff <= row_valid_ff[cur_ff] ? S_EVAL : S_DONE;
            end
            S_EVAL: begin
               case (e_act)
                  ACT_NONE: begin
                     state_ff <= S_DONE;
                  end
                  ACT_MOVE: begin
                     cur_ff <= rd_ff[11:8];
                     if (rd_ff[11:8] == start_state) begin
                        cnt_ff <= '0;
                        ovf_ff <= 1'b0;
                     end else if (cnt_ff < CNT_W'(MAX_TOKEN)) begin
                        buf_ff[cnt_ff[IDX_W-1:0]] <= char_ff;
                        cnt_ff <= cnt_ff + 1'b1;
                     end else begin
                        ovf_ff <= 1'b1;
                     end
                     state_ff <= S_DONE;
                  end
                  ACT_MOVE_REFEED: begin
                     cur_ff   <= rd_ff[11:8];
                     state_ff <= S_CHECK;
                  end
                  ACT_EMIT: begin
                     type_ff <= rd_ff[7:0];
                     idx_ff  <= '0;
                     if (cnt_ff == '0) begin
                        ovf_ff   <= 1'b0;
                        cur_ff   <= start_state;
                        state_ff <= S_CHECK;
                     end else begin
                        state_ff <= S_STREAM;
                     end
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_STREAM: begin
               idx_ff <= idx_ff + 1'b1;
               if (CNT_W'(idx_ff) == cnt_ff - 1'b1) begin
                  cnt_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  cur_ff   <= start_state;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (pass_end) begin
                  state_ff <= S_DONE;
               end else begin
                  pass_ff  <= pass_ff + 1'b1;
                  state_ff <= S_LOOKUP;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb_table_driven_lexer_fsm_top.sv =====
`default_nettype none
module tb_table_driven_lexer_fsm_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tdl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [3:0] csr_data;

   table_driven_lexer_fsm_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Lexer shadow state.
   logic [15:0] lex_table [NUM_STATES][256];
   bit          lex_written [NUM_STATES][256];
   bit          lex_row_ok [NUM_STATES];
   logic [3:0]  lex_start_state;
   logic [3:0]  lex_state;
   logic [7:0]  lex_buf [MAX_TOKEN];
   int          lex_count;
   bit          lex_overflow;
   logic [31:0] lex_position;

   req_type pending_cmds[$];
   rsp_type expected_tokens[$];
   int      fail_count;
   int      idle_cycles;
   int      gap_left;
   bit      req_taken;

   task automatic queue_cmd(input req_type c);
      begin
         pending_cmds = {pending_cmds, c};
      end
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [7:0] ch,
                              input logic [7:0] ty, input bit trunc,
                              input logic [31:0] pos);
      rsp_type r;
      begin
         r.kind = kind;
         r.token_char = ch;
         r.token_type = ty;
         r.last = 1'b0;
         r.truncated = trunc;
         r.position = pos;
         expected_tokens = {expected_tokens, r};
      end
   endtask

   task automatic predict_lexer(input req_type cmd);
      int first;
      int passes;
      logic [2:0] e_act;
      logic [3:0] e_nxt;
      logic [7:0] e_type;
      bit done;
      begin
         first = expected_tokens.size();
         case (cmd.op)
            OP_ADD_ROW: begin
               lex_row_ok[cmd.state_id] = 1'b1;
               for (int c = 0; c < 256; c++) lex_written[cmd.state_id][c] = 1'b0;
            end
            OP_RANGE: begin
               for (int c = cmd.char_low; c <= cmd.char_high; c++) begin
                  lex_table[cmd.state_id][c] = {1'b0, cmd.action, cmd.next_state,
                                                cmd.token_kind};
                  lex_written[cmd.state_id][c] = 1'b1;
               end
            end
            OP_RESTART: begin
               lex_state = lex_start_state;
               lex_count = 0;
               lex_overflow = 1'b0;
               lex_position = '0;
            end
            default: begin
               passes = 0;
               done = 1'b0;
               while (!done) begin
                  passes++;
                  if (!lex_row_ok[lex_state]) begin
                     push_result(KIND_INVALID, 8'd0, 8'd0, 1'b0, lex_position);
                     break;
                  end
                  if (!lex_written[lex_state][cmd.in_char]) begin
                     e_act = ACT_ERROR;
                     e_nxt = '0;
                     e_type = '0;
                  end else begin
                     e_act = lex_table[lex_state][cmd.in_char][14:12];
                     e_nxt = lex_table[lex_state][cmd.in_char][11:8];
                     e_type = lex_table[lex_state][cmd.in_char][7:0];
                  end
                  if (e_act == ACT_NONE) break;
                  if (e_act == ACT_MOVE) begin
                     lex_state = e_nxt;
                     if (e_nxt == lex_start_state) begin
                        lex_count = 0;
                        lex_overflow = 1'b0;
                     end else if (lex_count < MAX_TOKEN) begin
                        lex_buf[lex_count] = cmd.in_char;
                        lex_count++;
                     end else begin
                        lex_overflow = 1'b1;
                     end
                     break;
                  end
                  if (e_act == ACT_MOVE_REFEED) begin
                     lex_state = e_nxt;
                  end else if (e_act == ACT_EMIT) begin
                     if (lex_count == 0)
                        push_result(KIND_EMPTY, 8'd0, e_type, lex_overflow, lex_position);
                     else
                        for (int i = 0; i < lex_count; i++)
                           push_result(KIND_CHAR, lex_buf[i], e_type, lex_overflow,
                                       lex_position);
                     lex_count = 0;
                     lex_overflow = 1'b0;
                     lex_state = lex_start_state;
                  end else begin
                     push_result(KIND_ERROR, 8'd0, 8'd0, 1'b0, lex_position);
                     break;
                  end
                  if (passes >= MAX_REFEED) begin
                     push_result(KIND_ERROR, 8'd0, 8'd0, 1'b0, lex_position);
                     done = 1'b1;
                  end
               end
               lex_position = lex_position + 32'd1;
            end
         endcase
         if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
   endtask

   function automatic req_type make_cmd(input op_code_type op, input logic [3:0] sid,
                                        input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [3:0] nxt, input logic [2:0] act,
                                        input logic [7:0] tk, input logic [7:0] ch);
      req_type c;
      c.op = op;
      c.state_id = sid;
      c.char_low = lo;
      c.char_high = hi;
      c.next_state = nxt;
      c.action = act;
      c.token_kind = tk;
      c.in_char = ch;
      return c;
   endfunction

   function automatic req_type random_cmd(input op_code_type op);
      req_type c;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      c = raw[$bits(req_type)-1:0];
      c.op = op;
      return c;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Feeds a byte whose entry the stimulus knows to be written, within 64 retries, unless noise.
   function automatic logic [7:0] feed_char(input bit allow_unwritten);
      logic [7:0] ch;
      int tries;
      tries = 0;
      ch = 8'($urandom);
      while (!allow_unwritten && lex_row_ok[lex_state] &&
             !lex_written[lex_state][ch] && tries < 64) begin
         ch = 8'($urandom);
         tries++;
      end
      return ch;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else if (start && req_taken) begin
         // Transaction taken at the last rising edge.
         if (pending_cmds.size() > 0 && gap_left == 0) begin
            req_data <= pending_cmds.pop_front();
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (pending_cmds.size() > 0) begin
            req_data <= pending_cmds.pop_front();
            start <= 1'b1;
            gap_left = pick_gap();
         end
      end
   end

   // Prediction at acceptance, checking of results.
   always @(posedge clock) begin
      req_taken = !reset && start && !busy;
      if (!reset) begin
         if (req_taken) begin
            predict_lexer(req_data);
         end
         if (csr_valid && csr_ready) begin
            lex_start_state = csr_data;
         end
         if (rsp_valid) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected result kind=%0d", rsp_data.kind);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_tokens.pop_front();
               if (rsp_data.kind !== e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_data.kind); fail_count++;
               end
               if (rsp_data.token_char !== e.token_char) begin
                  $error("token_char exp %0h got %0h", e.token_char, rsp_data.token_char);
                  fail_count++;
               end
               if (rsp_data.token_type !== e.token_type) begin
                  $error("token_type exp %0h got %0h", e.token_type, rsp_data.token_type);
                  fail_count++;
               end
               if (rsp_data.last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_data.last); fail_count++;
               end
               if (rsp_data.truncated !== e.truncated) begin
                  $error("truncated exp %0d got %0d", e.truncated, rsp_data.truncated);
                  fail_count++;
               end
               if (rsp_data.position !== e.position) begin
                  $error("position exp %0d got %0d", e.position, rsp_data.position);
                  fail_count++;
               end
            end
         end
         if (req_taken || (csr_valid && csr_ready) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("table_driven_lexer_fsm_top verification failed");
            $finish;
         end
      end
   end

   // The tail leaves room for a sweep and one queued command to finish.
   task automatic wait_drained();
      begin
         while (pending_cmds.size() > 0 || start || expected_tokens.size() > 0 || busy)
            @(posedge clock);
         repeat (600) @(posedge clock);
      end
   endtask

   task automatic write_start_state(input logic [3:0] value);
      begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_data <= value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
         csr_valid <= 1'b0;
      end
   endtask

   // Adds a small grammar: identifiers of letters in row s1, spaces emit.
   task automatic queue_grammar(input logic [3:0] s0, input logic [3:0] s1,
                                input logic [7:0] tk);
      begin
         queue_cmd(make_cmd(OP_ADD_ROW, s0, '0, '0, '0, '0, '0, '0));
         queue_cmd(make_cmd(OP_ADD_ROW, s1, '0, '0, '0, '0, '0, '0));
         queue_cmd(make_cmd(OP_RANGE, s0, 8'h61, 8'h7a, s1, ACT_MOVE, tk, '0));
         queue_cmd(make_cmd(OP_RANGE, s0, 8'h20, 8'h20, s0, ACT_NONE, '0, '0));
         queue_cmd(make_cmd(OP_RANGE, s1, 8'h61, 8'h7a, s1, ACT_MOVE, tk, '0));
         queue_cmd(make_cmd(OP_RANGE, s1, 8'h20, 8'h2f, s0, ACT_EMIT, tk, '0));
         queue_cmd(make_cmd(OP_RANGE, s1, 8'h30, 8'h39, s0,
                            ACT_MOVE_REFEED, tk + 8'd1, '0));
         queue_cmd(make_cmd(OP_RANGE, s0, 8'h30, 8'h39, s1,
                            ACT_MOVE_REFEED, tk, '0));
         queue_cmd(make_cmd(OP_RESTART, '0, '0, '0, '0, '0, '0, '0));
      end
   endtask

   initial begin
      req_type c;
      int n;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      fail_count = 0;
      idle_cycles = 0;
      gap_left = 0;
      req_taken = 1'b0;
      lex_start_state = '0;
      lex_state = '0;
      lex_count = 0;
      lex_overflow = 1'b0;
      lex_position = '0;
      for (int s = 0; s < NUM_STATES; s++) lex_row_ok[s] = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: invalid state feed, then a grammar with edge cases.
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h00));
      queue_grammar(4'd0, 4'd15, 8'hff);
      queue_cmd(make_cmd(OP_RANGE, 4'd0, 8'h80, 8'h7f, 4'd0, ACT_MOVE, '0, '0));
      queue_cmd(make_cmd(OP_RANGE, 4'd0, 8'hf0, 8'hff, 4'd0, ACT_ERROR, '0, '0));
      queue_cmd(make_cmd(OP_RANGE, 4'd0, 8'h00, 8'h00, 4'd0, 3'd7, 8'h00, '0));
      queue_cmd(make_cmd(OP_RANGE, 4'd15, 8'hff, 8'hff, 4'd15, ACT_MOVE_REFEED, '0, '0));
      queue_cmd(make_cmd(OP_RANGE, 4'd15, 8'h3a, 8'h3a, 4'd0, ACT_EMIT, 8'h5a, '0));
      queue_cmd(make_cmd(OP_RANGE, 4'd7, 8'h00, 8'hff, 4'd1, ACT_MOVE, '0, '0));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h61));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h7a));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h20));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h31));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'hff));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h3a));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h00));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h80));
      wait_drained();

      // Random phases over several start states.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_start_state(4'd15);
            1: write_start_state(4'd0);
            default: write_start_state(4'($urandom_range(0, 15)));
         endcase
         queue_grammar(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       8'($urandom));
         wait_drained();
         n = 0;
         while (n < 19) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
               c = random_cmd(OP_FEED);
               // Feed bytes are chosen as the shadow state is at queue time;
               // the queue is drained before each pick so it stays accurate.
               c.in_char = feed_char(r < 5);
               if (r > 55) c.in_char = 8'($urandom_range(8'h61, 8'h7a));
            end else if (r < 82) begin
               c = random_cmd(OP_RANGE);
               if ($urandom_range(0, 3) != 0) c.action = 3'($urandom_range(0, 4));
               if ($urandom_range(0, 2) != 0)
                  c.char_high = c.char_low + 8'($urandom_range(0, 15));
            end else if (r < 88) begin
               c = random_cmd(OP_ADD_ROW);
            end else begin
               c = random_cmd(OP_RESTART);
            end
            queue_cmd(c);
            while (pending_cmds.size() > 0 || start) @(posedge clock);
            n++;
         end
         wait_drained();
      end

      // Long token to hit buffer overflow and truncation.
      write_start_state(4'd3);
      queue_grammar(4'd3, 4'd9, 8'h11);
      for (int i = 0; i < 36; i++)
         queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0,
                            8'($urandom_range(8'h61, 8'h7a))));
      queue_cmd(make_cmd(OP_FEED, '0, '0, '0, '0, '0, '0, 8'h2f));
      wait_drained();

      if (fail_count == 0)
         $display("table_driven_lexer_fsm_top verification clean");
      else
         $display("table_driven_lexer_fsm_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire
